/* rtl/gbgp_pkg.sv */
package gbgp_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_TEXT_SHADE   = 2'd0;
  localparam logic [1:0] CFG_BACK_SHADE   = 2'd1;
  localparam logic [1:0] CFG_GLYPH_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd3;

  // register reset values
  localparam logic [3:0] TEXT_SHADE_RST   = 4'd15;
  localparam logic [3:0] BACK_SHADE_RST   = 4'd0;
  localparam logic [5:0] GLYPH_WIDTH_RST  = 6'd8;
  localparam logic [5:0] GLYPH_HEIGHT_RST = 6'd16;

  // limits of the glyph geometry
  localparam logic [4:0] MAX_ROW_BYTES  = 5'd16;
  localparam logic [5:0] MAX_ROWS       = 6'd32;
  localparam logic [4:0] MAX_PER_ITEM   = 5'd4;

  // what the position tracker decides for one font byte
  typedef struct packed {
    logic [2:0] count;      // output bytes this item gives, 1..4
    logic       glyph_end;  // last of them closes the glyph
  } gbgp_plan_t;

endpackage

/* rtl/gbgp_pos.sv */
module gbgp_pos import gbgp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [5:0] glyph_width,
  input  logic [5:0] glyph_height,
  output gbgp_plan_t plan
);

  logic [3:0] column_pos_r, column_pos_nxt;
  logic [4:0] row_pos_r, row_pos_nxt;
  logic [4:0] row_bytes;
  logic [5:0] rows;
  logic [4:0] left;
  logic [2:0] count;
  logic       row_ends;
  logic       last_row;

  // clamp the glyph geometry
  always_comb begin
    row_bytes = glyph_width[5:1];
    if (row_bytes == 5'd0) begin
      row_bytes = 5'd1;
    end else if (row_bytes > MAX_ROW_BYTES) begin
      row_bytes = MAX_ROW_BYTES;
    end
    rows = glyph_height;
    if (rows == 6'd0) begin
      rows = 6'd1;
    end else if (rows > MAX_ROWS) begin
      rows = MAX_ROWS;
    end
  end

  // bytes left in the row and how many this item covers
  always_comb begin
    left = ({1'b0, column_pos_r} < row_bytes) ? (row_bytes - {1'b0, column_pos_r}) : 5'd1;
    row_ends = (left <= MAX_PER_ITEM);
    count = row_ends ? left[2:0] : MAX_PER_ITEM[2:0];
    last_row = ({1'b0, row_pos_r} + 6'd1 >= rows);
  end

  assign plan.count     = count;
  assign plan.glyph_end = row_ends & last_row;

  // next position in the glyph
  always_comb begin
    column_pos_nxt = column_pos_r;
    row_pos_nxt    = row_pos_r;
    if (advance) begin
      if (row_ends) begin
        column_pos_nxt = 4'd0;
        row_pos_nxt    = last_row ? 5'd0 : row_pos_r + 5'd1;
      end else begin
        column_pos_nxt = column_pos_r + {1'b0, count};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_pos_r <= 4'd0;
      row_pos_r    <= 5'd0;
    end else begin
      column_pos_r <= column_pos_nxt;
      row_pos_r    <= row_pos_nxt;
    end
  end

endmodule

/* rtl/glyph_bitmap_to_gray_pixels_unit.sv */
// channel   ports                                      direction
// input     in_valid, in_stall, in_font_bits[7:0]      font byte in
// result    out_valid, out_stall, out_pixel_pair[7:0],
//           out_run_last, out_glyph_done               gray byte out
// config    cfg_we, cfg_index[1:0], cfg_wdata[5:0]     register write
//
// a font byte sits in the input register until each output byte it gives (1 to
// 4 of them, 4 for every byte that does not end a row) has moved on; the single
// output register takes one byte a cycle while out_stall does not hold it.
// the next font byte is taken in the cycle the last output byte of the current
// one moves to the output register. reset clears the glyph position, both
// valid flags and loads the register defaults. out_stall holds the output
// register and, through it, the input register.
module glyph_bitmap_to_gray_pixels_unit import gbgp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_font_bits,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_pixel_pair,
  output logic       out_run_last,
  output logic       out_glyph_done,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata
);

  logic [3:0] text_shade_r;
  logic [3:0] back_shade_r;
  logic [5:0] glyph_width_r;
  logic [5:0] glyph_height_r;

  logic       hold_valid_r, hold_valid_nxt;
  logic [7:0] hold_bits_r, hold_bits_nxt;
  logic [2:0] hold_cnt_r, hold_cnt_nxt;
  logic       hold_end_r, hold_end_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_pixel_pair_r, out_pixel_pair_nxt;
  logic       out_run_last_r, out_run_last_nxt;
  logic       out_glyph_done_r, out_glyph_done_nxt;

  logic       out_adv;
  logic       emit;
  logic       hold_last;
  logic       in_take;
  gbgp_plan_t plan;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_shade_r   <= TEXT_SHADE_RST;
      back_shade_r   <= BACK_SHADE_RST;
      glyph_width_r  <= GLYPH_WIDTH_RST;
      glyph_height_r <= GLYPH_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_SHADE:   text_shade_r   <= cfg_wdata[3:0];
        CFG_BACK_SHADE:   back_shade_r   <= cfg_wdata[3:0];
        CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_wdata;
        CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_adv   = !out_valid_r || !out_stall;
  assign emit      = hold_valid_r && out_adv;
  assign hold_last = (hold_cnt_r == 3'd1);
  assign in_stall  = hold_valid_r && !(emit && hold_last);
  assign in_take   = in_valid && !in_stall;

  gbgp_pos u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_take),
    .glyph_width  (glyph_width_r),
    .glyph_height (glyph_height_r),
    .plan         (plan)
  );

  // input register: font byte and remaining output bytes
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_bits_nxt  = hold_bits_r;
    hold_cnt_nxt   = hold_cnt_r;
    hold_end_nxt   = hold_end_r;
    if (emit) begin
      hold_bits_nxt = {hold_bits_r[5:0], 2'b00};
      hold_cnt_nxt  = hold_cnt_r - 3'd1;
      if (hold_last) begin
        hold_valid_nxt = 1'b0;
      end
    end
    if (in_take) begin
      hold_valid_nxt = 1'b1;
      hold_bits_nxt  = in_font_bits;
      hold_cnt_nxt   = plan.count;
      hold_end_nxt   = plan.glyph_end;
    end
  end

  // output register: expand the top two bits into one gray byte
  always_comb begin
    out_valid_nxt      = out_valid_r;
    out_pixel_pair_nxt = out_pixel_pair_r;
    out_run_last_nxt   = out_run_last_r;
    out_glyph_done_nxt = out_glyph_done_r;
    if (out_adv) begin
      out_valid_nxt      = emit;
      out_pixel_pair_nxt = {hold_bits_r[7] ? text_shade_r : back_shade_r,
                            hold_bits_r[6] ? text_shade_r : back_shade_r};
      out_run_last_nxt   = hold_last;
      out_glyph_done_nxt = hold_last && hold_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    hold_bits_r      <= hold_bits_nxt;
    hold_cnt_r       <= hold_cnt_nxt;
    hold_end_r       <= hold_end_nxt;
    out_pixel_pair_r <= out_pixel_pair_nxt;
    out_run_last_r   <= out_run_last_nxt;
    out_glyph_done_r <= out_glyph_done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_pair = out_pixel_pair_r;
  assign out_run_last   = out_run_last_r;
  assign out_glyph_done = out_glyph_done_r;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import gbgp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DIRECTED_ROWS = 37;
  localparam int RANDOM_ITEMS  = 289;

  // one expected gray byte
  typedef struct packed {
    logic [7:0] pixel_pair;
    logic       run_last;
    logic       glyph_done;
  } gray_byte_t;

  // directed stimulus: either a font byte or a register write
  typedef enum logic {ROW_FONT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] reg_index;
    logic [5:0] reg_value;
    logic [7:0] font;
    logic       pair_known;
    logic [7:0] pair;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_font_bits;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_pixel_pair;
  logic       out_run_last;
  logic       out_glyph_done;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [5:0] cfg_wdata;

  // predictor copy of the registers and glyph position
  logic [3:0] shade_text;
  logic [3:0] shade_back;
  logic [5:0] width_reg;
  logic [5:0] height_reg;
  logic [3:0] col_q;
  logic [4:0] row_q;

  gray_byte_t expected_bytes[$];
  stim_row_t  directed_rows [DIRECTED_ROWS];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         burst = 1'b0;

  glyph_bitmap_to_gray_pixels_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_font_bits   (in_font_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_pair (out_pixel_pair),
    .out_run_last   (out_run_last),
    .out_glyph_done (out_glyph_done),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, expected_bytes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    $display("mismatch on %s at cycle %0d: got %h, expected %h",
             field, cycle_count, got, want);
  endtask

  // expand one font byte into the gray bytes it should give
  task automatic expand_font_byte(input logic [7:0] fb, input logic pair_known,
                                  input logic [7:0] pair);
    int         row_bytes;
    int         rows;
    int         left;
    int         count;
    bit         row_ends;
    bit         last_row;
    logic [7:0] bits;
    logic [3:0] hi;
    logic [3:0] lo;
    gray_byte_t gb;
    row_bytes = int'(width_reg) >> 1;
    if (row_bytes < 1) row_bytes = 1;
    if (row_bytes > int'(MAX_ROW_BYTES)) row_bytes = int'(MAX_ROW_BYTES);
    rows = int'(height_reg);
    if (rows < 1) rows = 1;
    if (rows > int'(MAX_ROWS)) rows = int'(MAX_ROWS);
    // a column already past the row end gives one closing byte
    left = (int'(col_q) < row_bytes) ? row_bytes - int'(col_q) : 1;
    count = (left < int'(MAX_PER_ITEM)) ? left : int'(MAX_PER_ITEM);
    row_ends = (count == left);
    last_row = (int'(row_q) + 1 >= rows);
    bits = fb;
    for (int k = 0; k < count; k++) begin
      hi = bits[7] ? shade_text : shade_back;
      lo = bits[6] ? shade_text : shade_back;
      gb.pixel_pair = pair_known ? pair : {hi, lo};
      gb.run_last = (k == count - 1);
      gb.glyph_done = gb.run_last && row_ends && last_row;
      expected_bytes.push_back(gb);
      bits = bits << 2;
    end
    if (row_ends) begin
      col_q = '0;
      row_q = last_row ? '0 : row_q + 5'd1;
    end else begin
      col_q = col_q + 4'(count);
    end
  endtask

  // offer one font byte after a random gap (none in burst mode), wait for it to be taken
  task automatic send_font(input logic [7:0] fb, input logic pair_known,
                           input logic [7:0] pair);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_font_bits = fb;
    do @(posedge clk); while (in_stall !== 1'b0);
    expand_font_byte(fb, pair_known, pair);
  endtask

  // drop valid and let every expected byte come out
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [5:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(posedge clk);
    case (index)
      CFG_TEXT_SHADE:   shade_text = value[3:0];
      CFG_BACK_SHADE:   shade_back = value[3:0];
      CFG_GLYPH_WIDTH:  width_reg = value;
      CFG_GLYPH_HEIGHT: height_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side: random stall (none in burst mode), then take one item and check it
  initial begin : result_check
    gray_byte_t want;
    int         hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = burst ? 0 : $urandom_range(0, 5);
      repeat (hold) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected item", out_pixel_pair, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        if (out_pixel_pair !== want.pixel_pair)
          report_mismatch("pixel_pair", out_pixel_pair, want.pixel_pair);
        if (out_run_last !== want.run_last)
          report_mismatch("run_last", {7'd0, out_run_last}, {7'd0, want.run_last});
        if (out_glyph_done !== want.glyph_done)
          report_mismatch("glyph_done", {7'd0, out_glyph_done}, {7'd0, want.glyph_done});
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int sent;
    int batch;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_font_bits = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TEXT_SHADE;
    cfg_wdata = '0;
    shade_text = TEXT_SHADE_RST;
    shade_back = BACK_SHADE_RST;
    width_reg = GLYPH_WIDTH_RST;
    height_reg = GLYPH_HEIGHT_RST;
    col_q = '0;
    row_q = '0;

    directed_rows = '{
      // reset shades: uniform bytes read straight off
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'hFF, 1'b1, 8'hFF},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h00, 1'b1, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'hAA, 1'b1, 8'hF0},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h55, 1'b1, 8'h0F},
      // shades with upper write bits set
      '{ROW_CFG,  CFG_TEXT_SHADE,   6'h3A, 8'h00, 1'b0, 8'h00},
      '{ROW_CFG,  CFG_BACK_SHADE,   6'h25, 8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'hC6, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h3C, 1'b0, 8'h00},
      // narrow width and zero height: every byte is a glyph
      '{ROW_CFG,  CFG_GLYPH_WIDTH,  6'd0,  8'h00, 1'b0, 8'h00},
      '{ROW_CFG,  CFG_GLYPH_HEIGHT, 6'd0,  8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h80, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h01, 1'b0, 8'h00},
      // wide width, tall height, stop mid row
      '{ROW_CFG,  CFG_GLYPH_WIDTH,  6'd63, 8'h00, 1'b0, 8'h00},
      '{ROW_CFG,  CFG_GLYPH_HEIGHT, 6'd63, 8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'hE7, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h18, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h99, 1'b0, 8'h00},
      // shrink width: column now past the row end
      '{ROW_CFG,  CFG_GLYPH_WIDTH,  6'd4,  8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h42, 1'b0, 8'h00},
      // shrink height: row now past the glyph end
      '{ROW_CFG,  CFG_GLYPH_HEIGHT, 6'd1,  8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'hBD, 1'b0, 8'h00},
      '{ROW_CFG,  CFG_GLYPH_WIDTH,  6'd1,  8'h00, 1'b0, 8'h00},
      '{ROW_CFG,  CFG_GLYPH_HEIGHT, 6'd33, 8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h7E, 1'b0, 8'h00},
      // odd width drops its low bit
      '{ROW_CFG,  CFG_GLYPH_WIDTH,  6'd9,  8'h00, 1'b0, 8'h00},
      '{ROW_CFG,  CFG_GLYPH_HEIGHT, 6'd2,  8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'hFF, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h81, 1'b0, 8'h00},
      // full-scale shades, then swapped
      '{ROW_CFG,  CFG_TEXT_SHADE,   6'h0F, 8'h00, 1'b0, 8'h00},
      '{ROW_CFG,  CFG_BACK_SHADE,   6'h00, 8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'hFF, 1'b1, 8'hFF},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h00, 1'b1, 8'h00},
      '{ROW_CFG,  CFG_TEXT_SHADE,   6'h00, 8'h00, 1'b0, 8'h00},
      '{ROW_CFG,  CFG_BACK_SHADE,   6'h0F, 8'h00, 1'b0, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'hFF, 1'b1, 8'h00},
      '{ROW_FONT, CFG_TEXT_SHADE,   6'h00, 8'h00, 1'b1, 8'hFF}
    };

    // synchronous reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_font(directed_rows[i].font, directed_rows[i].pair_known,
                  directed_rows[i].pair);
      end
    end

    // random phases, small glyphs most of the time so glyphs complete often
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 1))
        write_reg(CFG_TEXT_SHADE, 6'($urandom_range(0, 63)));
      if ($urandom_range(0, 1))
        write_reg(CFG_BACK_SHADE, 6'($urandom_range(0, 63)));
      if ($urandom_range(0, 1))
        write_reg(CFG_GLYPH_WIDTH, ($urandom_range(0, 9) < 7) ?
                  6'($urandom_range(2, 10)) : 6'($urandom_range(0, 63)));
      if ($urandom_range(0, 1))
        write_reg(CFG_GLYPH_HEIGHT, ($urandom_range(0, 9) < 7) ?
                  6'($urandom_range(1, 4)) : 6'($urandom_range(0, 63)));
      burst = ($urandom_range(0, 3) == 0);
      batch = $urandom_range(8, 40);
      if (batch > RANDOM_ITEMS - sent) batch = RANDOM_ITEMS - sent;
      repeat (batch) begin
        send_font(8'($urandom_range(0, 255)), 1'b0, 8'h00);
        sent++;
      end
    end
    burst = 1'b0;

    // drain and finish
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
